// File: sv/nmsc_pkg.sv
// ----------------------------------------------------------------------------
// NMEA sentence checker package
// Shared types, character codes, status codes and the hex digit decoder.
// ----------------------------------------------------------------------------
package nmsc_pkg;

   localparam logic [7:0]  CHAR_DOLLAR = 8'h24;
   localparam logic [7:0]  CHAR_STAR   = 8'h2A;

   localparam logic [39:0] TAG_RESET   = 40'h4750474741;
   localparam logic [15:0] IDLE_RESET  = 16'd200;
   localparam logic [15:0] IDLE_MAX    = 16'hFFFF;

   localparam logic        FUNC_BYTE   = 1'b0;
   localparam logic        FUNC_IDLE   = 1'b1;

   localparam logic        CSR_TAG     = 1'b0;
   localparam logic        CSR_IDLE    = 1'b1;

   localparam logic [2:0]  ST_MATCH    = 3'd0;
   localparam logic [2:0]  ST_OTHER    = 3'd1;
   localparam logic [2:0]  ST_MISMATCH = 3'd2;
   localparam logic [2:0]  ST_BADHEX   = 3'd3;
   localparam logic [2:0]  ST_LONG     = 3'd4;
   localparam logic [2:0]  ST_TIMEOUT  = 3'd5;

   typedef enum logic [3:0] {
      PH_HUNT = 4'b0001,
      PH_BODY = 4'b0010,
      PH_HEX1 = 4'b0100,
      PH_HEX2 = 4'b1000
   } phase_type;

   typedef struct packed {
      logic       vld;
      logic [2:0] status;
      logic [7:0] len;
      logic [7:0] csum;
   } result_type;

   // bit 4 set: not a hex digit
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b0, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r = {1'b0, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

// File: sv/nmsc_parse.sv
// ----------------------------------------------------------------------------
// NMEA sentence parser
// Per-beat update: hunt, body XOR, two checksum digits, length and idle limits.
// ----------------------------------------------------------------------------
module nmsc_parse
   import nmsc_pkg::*;
#(
   parameter int MAX_LEN = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        item_vld,
   input  logic        item_func,
   input  logic [7:0]  item_data,
   input  logic [39:0] tag,
   input  logic [15:0] idle_limit,
   output result_type  res
);

   localparam int CntW = $clog2(MAX_LEN + 1);
   localparam int LenW = (CntW > 8) ? CntW : 8;

   phase_type        phase_ff, phase_in;
   logic [7:0]       xor_ff, xor_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [3:0]       nib_ff, nib_in;
   logic             bad_ff, bad_in;
   logic             match_ff, match_in;
   logic [15:0]      idle_ff, idle_in;

   logic [4:0]       hex;
   logic [2:0]       tsel;
   logic [7:0]       tag_byte;
   logic [LenW-1:0]  len_wide;
   logic [CntW-1:0]  cnt_inc;

   always_comb begin
      hex  = hex_decode(item_data);
      tsel = 3'd5 - cnt_ff[2:0];
      case (tsel)
         3'd0:    tag_byte = tag[7:0];
         3'd1:    tag_byte = tag[15:8];
         3'd2:    tag_byte = tag[23:16];
         3'd3:    tag_byte = tag[31:24];
         3'd4:    tag_byte = tag[39:32];
         default: tag_byte = 8'h00;
      endcase
      cnt_inc = cnt_ff + CntW'(1);
   end

   always_comb begin
      phase_in = phase_ff;
      xor_in   = xor_ff;
      cnt_in   = cnt_ff;
      nib_in   = nib_ff;
      bad_in   = bad_ff;
      match_in = match_ff;
      idle_in  = idle_ff;
      res.vld    = 1'b0;
      res.status = ST_MATCH;
      len_wide   = LenW'(cnt_ff);

      if (item_vld) begin
         if (item_func == FUNC_IDLE) begin
            if (idle_ff != IDLE_MAX) begin
               idle_in = idle_ff + 16'd1;
            end
            if (phase_ff != PH_HUNT && idle_in > idle_limit) begin
               res.vld    = 1'b1;
               res.status = ST_TIMEOUT;
            end
         end else begin
            idle_in = '0;
            if (phase_ff == PH_HUNT) begin
               if (item_data == CHAR_DOLLAR) begin
                  phase_in = PH_BODY;
                  cnt_in   = CntW'(1);
               end
            end else if (cnt_ff >= CntW'(MAX_LEN)) begin
               res.vld    = 1'b1;
               res.status = ST_LONG;
            end else begin
               cnt_in = cnt_inc;
               if (cnt_ff <= CntW'(5) && tag_byte != item_data) begin
                  match_in = 1'b0;
               end
               case (phase_ff)
                  PH_BODY: begin
                     if (item_data == CHAR_STAR) begin
                        phase_in = PH_HEX1;
                     end else begin
                        xor_in = xor_ff ^ item_data;
                     end
                  end
                  PH_HEX1: begin
                     if (hex[4]) begin
                        bad_in = 1'b1;
                     end else begin
                        nib_in = hex[3:0];
                     end
                     phase_in = PH_HEX2;
                  end
                  default: begin
                     len_wide = LenW'(cnt_inc);
                     res.vld  = 1'b1;
                     if (cnt_inc < CntW'(6)) begin
                        match_in = 1'b0;
                     end
                     if (bad_ff || hex[4]) begin
                        res.status = ST_BADHEX;
                     end else if ({nib_ff, hex[3:0]} != xor_ff) begin
                        res.status = ST_MISMATCH;
                     end else begin
                        res.status = match_in ? ST_MATCH : ST_OTHER;
                     end
                  end
               endcase
            end
         end

         if (res.vld) begin
            phase_in = PH_HUNT;
            xor_in   = '0;
            cnt_in   = '0;
            nib_in   = '0;
            bad_in   = 1'b0;
            match_in = 1'b1;
         end
      end

      res.len  = (len_wide > LenW'(255)) ? 8'hFF : len_wide[7:0];
      res.csum = xor_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         xor_ff   <= '0;
         cnt_ff   <= '0;
         nib_ff   <= '0;
         bad_ff   <= 1'b0;
         match_ff <= 1'b1;
         idle_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         xor_ff   <= xor_in;
         cnt_ff   <= cnt_in;
         nib_ff   <= nib_in;
         bad_ff   <= bad_in;
         match_ff <= match_in;
         idle_ff  <= idle_in;
      end
   end

endmodule

// File: sv/nmsc_rsp_reg.sv
// ----------------------------------------------------------------------------
// NMEA sentence result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module nmsc_rsp_reg
   import nmsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  result_type res,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_sentence_length,
   output logic [7:0] rsp_computed_checksum
);

   logic       vld_ff;
   logic [2:0] status_ff;
   logic [7:0] len_ff;
   logic [7:0] csum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (res.vld) begin
         vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res.vld) begin
         status_ff <= res.status;
         len_ff    <= res.len;
         csum_ff   <= res.csum;
      end
   end

   assign rsp_valid             = vld_ff;
   assign rsp_status            = status_ff;
   assign rsp_sentence_length   = len_ff;
   assign rsp_computed_checksum = csum_ff;

endmodule

// File: sv/nmea_sentence_checker.sv
// ----------------------------------------------------------------------------
// NMEA sentence checker
// Validates NMEA 0183 sentences from a byte stream: XOR checksum, tag match,
// length limit and idle timeout, one result beat per finished sentence.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_func, req_data_byte
//   rsp      out        rsp_valid/rsp_ready    rsp_status, rsp_sentence_length,
//                                              rsp_computed_checksum
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One beat per cycle sustained while no rsp beat is held; rsp_valid rises once
// the accepted req beat passes the input register, then the result register.
// Synchronous reset loads the tag "GPGGA" and an idle limit of 200.
// A held rsp beat stalls the parse stage; req_ready drops only while the
// input register is full and the result register is held.
// csr_ready is always high.
// ----------------------------------------------------------------------------
module nmea_sentence_checker
   import nmsc_pkg::*;
#(
   parameter int MAX_LEN = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_sentence_length,
   output logic [7:0]  rsp_computed_checksum,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [39:0] csr_data
);

   localparam int LongLen = (MAX_LEN > 255) ? 255 : MAX_LEN;

   logic [39:0] tag_ff;
   logic [15:0] limit_ff;
   logic        in_vld_ff;
   logic        func_ff;
   logic [7:0]  data_ff;
   logic        stall;
   result_type  res;

   assign csr_ready = 1'b1;
   assign stall     = rsp_valid & ~rsp_ready;
   assign req_ready = ~in_vld_ff | ~stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff   <= TAG_RESET;
         limit_ff <= IDLE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TAG:  tag_ff   <= csr_data;
            CSR_IDLE: limit_ff <= csr_data[15:0];
            default:  tag_ff   <= tag_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         func_ff <= req_func;
         data_ff <= req_data_byte;
      end
   end

   nmsc_parse #(
      .MAX_LEN (MAX_LEN)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .item_vld   (in_vld_ff & ~stall),
      .item_func  (func_ff),
      .item_data  (data_ff),
      .tag        (tag_ff),
      .idle_limit (limit_ff),
      .res        (res)
   );

   nmsc_rsp_reg u_rsp (
      .clock                 (clock),
      .reset                 (reset),
      .res                   (res),
      .rsp_ready             (rsp_ready),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_sentence_length   (rsp_sentence_length),
      .rsp_computed_checksum (rsp_computed_checksum)
   );

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res.vld |-> !stall)
      else $error("result produced while output beat is held");

   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_vld_ff && rsp_valid && !rsp_ready))
      else $error("input stalled without a held output beat");

   a_match_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_MATCH) |-> (rsp_sentence_length >= 8'd6))
      else $error("tag match reported on a short sentence");

   a_long_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_LONG) |-> (rsp_sentence_length == 8'(LongLen)))
      else $error("too-long status with wrong length");

endmodule
